FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the divider RTL.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

FILE: hw/rtl/frd_pkg.sv
// Types and constants for the restoring float divider.
// No dependencies.
`default_nettype none
package frd_pkg;
    localparam int unsigned FRAC_W   = 23;
    localparam int unsigned EXP_W    = 8;
    localparam int unsigned REM_W    = 26;
    localparam int unsigned QUO_W    = 25;
    localparam int unsigned STEPS    = 25;
    localparam logic [EXP_W-1:0] EXP_BIAS = 8'd127;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [FRAC_W:0]   den;
        logic [QUO_W-1:0]  quo;
        logic [EXP_W-1:0]  expo;
    } frd_work_t;
endpackage
`default_nettype wire

FILE: hw/rtl/frd_cell.sv
// One restoring division step with its pipeline register and stall control.
// Depends on frd_pkg.
`default_nettype none
module frd_cell
    import frd_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire frd_work_t in_work,
    output logic           out_valid,
    input  wire logic      out_ready,
    output frd_work_t      out_work
);
    logic      valid_reg;
    frd_work_t work_reg;
    frd_work_t work_next;
    logic [REM_W-1:0] diff;
    logic             ge;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        ge   = in_work.rem >= {2'b00, in_work.den};
        diff = ge ? (in_work.rem - {2'b00, in_work.den}) : in_work.rem;
        work_next      = in_work;
        work_next.rem  = {diff[REM_W-2:0], 1'b0};
        work_next.quo  = {in_work.quo[QUO_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/float_restoring_divider.sv
// Top level: operand unpack, chain of 25 division cells, output register.
// Depends on frd_pkg, frd_cell and assert_macros.svh.
//   channel | dir | tdata
//   s_axis  | in  | [31:0] dividend_bits, [63:32] divisor_bits
//   m_axis  | out | [30:0] quotient_bits, [31] zero
// Accepts one transaction per cycle while s_axis_tready is high; a result passes through
// 25 cell registers (the first loaded at the accepting edge), then the output register.
// Each cell stalls only when it holds an item and its successor cannot take it, so bubbles close up under stall.
// Reset clears all valid flags; payload registers are not reset.
`default_nettype none
`include "assert_macros.svh"
module float_restoring_divider
    import frd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // dividend_bits, divisor_bits
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // quotient_bits, zero pad
);
    frd_work_t        work  [STEPS+1];
    logic [STEPS:0]   valid;
    logic [STEPS:0]   ready;
    logic [FRAC_W:0]  num;
    logic [FRAC_W:0]  den;
    logic [EXP_W-1:0] e0;
    logic             lt;
    logic             out_valid_reg;
    logic [30:0]      out_data_reg;

    always_comb begin
        num = {1'b1, s_axis_tdata[FRAC_W-1:0]};
        den = {1'b1, s_axis_tdata[32+FRAC_W-1:32]};
        lt  = num < den;
        e0  = s_axis_tdata[30:23] - s_axis_tdata[62:55] + EXP_BIAS - {7'd0, lt};
        work[0].rem  = lt ? {1'b0, num, 1'b0} : {2'b00, num};
        work[0].den  = den;
        work[0].quo  = '0;
        work[0].expo = e0;
    end

    assign valid[0]      = s_axis_tvalid;
    assign s_axis_tready = ready[0];

    genvar g;
    generate
        for (g = 0; g < STEPS; g++) begin : g_cell
            frd_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (valid[g]),
                .in_ready  (ready[g]),
                .in_work   (work[g]),
                .out_valid (valid[g+1]),
                .out_ready (ready[g+1]),
                .out_work  (work[g+1])
            );
        end
    endgenerate

    assign ready[STEPS] = !out_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ready[STEPS]) begin
            out_valid_reg <= valid[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (ready[STEPS] && valid[STEPS]) begin
            out_data_reg <= {work[STEPS].expo, work[STEPS].quo[QUO_W-2:1]};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg};

    `ASSERT_CLK(a_out_hold, aclk, aresetn, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    `ASSERT_CLK(a_hidden_bit, aclk, aresetn, valid[STEPS] |-> work[STEPS].den[FRAC_W])
    `ASSERT_CLK(a_first_q_one, aclk, aresetn, valid[STEPS] |-> work[STEPS].quo[QUO_W-1])
    `ASSERT_NORST(a_reset_idle, aclk, !$past(aresetn) |-> !m_axis_tvalid)
endmodule
`default_nettype wire
